// File: src/crcfc_pkg.sv
// ----------------------------------------------------------------------------
// crcfc_pkg
// Shared types, codes and helpers of the CRC-32 frame checker.
// ----------------------------------------------------------------------------
package crcfc_pkg;

   localparam int MAX_FRAME_BYTES = 1024;
   localparam int LEN_CAP_INT     = 1023;
   localparam int FRAME_LIM_INT   = (MAX_FRAME_BYTES - 10 > LEN_CAP_INT) ?
                                    LEN_CAP_INT : MAX_FRAME_BYTES - 10;

   localparam logic [9:0]  FRAME_LEN_LIMIT = 10'(FRAME_LIM_INT);
   localparam logic [9:0]  LEN_CAP         = 10'(LEN_CAP_INT);
   localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;

   // Configuration register indexes
   localparam logic [1:0] CSR_START_MARKER = 2'd0;
   localparam logic [1:0] CSR_STOP_MARKER  = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH   = 2'd2;

   localparam logic [7:0] START_MARKER_RESET = 8'd1;
   localparam logic [7:0] STOP_MARKER_RESET  = 8'd1;
   localparam logic [9:0] MAX_LENGTH_RESET   = 10'd1014;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BAD_START = 3'd2,
      ST_EARLY     = 3'd3,
      ST_BAD_STOP  = 3'd4,
      ST_CRC       = 3'd5,
      ST_TOO_LONG  = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       reception_end;
   } req_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_byte;
      logic [2:0] frame_status;
      logic [9:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] stop_marker;
      logic [9:0] max_payload_length;
   } cfg_type;

   // Reflected CRC-32 update over one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: src/crc32_frame_checker.sv
// ----------------------------------------------------------------------------
// crc32_frame_checker
// Length-prefixed frame checker with CRC-32 over the payload.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_data  (rx_byte, reception_end)
//   rsp      out  rsp_valid/rsp_ready    rsp_data  (item_kind, payload_byte,
//                                                   frame_status, payload_length)
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One item is accepted per cycle while the rsp side does not stall. An item is
// first captured in the input register; from there the parser updates the frame
// state and loads the result register, which then shows the result. The
// byte-wide CRC-32 update sets the longest path in the parser.
// A stalled rsp side holds the result register; the input register then
// fills and req_ready drops. Reset clears all frame state and loads the
// configuration defaults; csr writes are always taken (csr_ready is high).
//
module crc32_frame_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crcfc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output crcfc_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [9:0]         csr_data
);
   import crcfc_pkg::*;

   cfg_type cfg;
   logic    hold_valid;
   req_type hold_data;
   logic    take;
   logic    slot_free;
   logic    res_valid;
   rsp_type res_data;

   // Configuration registers: markers and payload length limit
   crcfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register; refills in the same cycle the parser takes its item
   crcfc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   // Parser: advance frame state only when the result register has room
   crcfc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .hold_valid (hold_valid),
      .hold_data  (hold_data),
      .slot_free  (slot_free),
      .take       (take),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   // Result register toward the consumer
   crcfc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/crcfc_csr.sv
// ----------------------------------------------------------------------------
// crcfc_csr
// Configuration registers of the frame checker.
// ----------------------------------------------------------------------------
module crcfc_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [9:0]         csr_data,
   output crcfc_pkg::cfg_type cfg
);
   import crcfc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker       <= START_MARKER_RESET;
         cfg_ff.stop_marker        <= STOP_MARKER_RESET;
         cfg_ff.max_payload_length <= MAX_LENGTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_MARKER: cfg_ff.start_marker       <= csr_data[7:0];
            CSR_STOP_MARKER:  cfg_ff.stop_marker        <= csr_data[7:0];
            CSR_MAX_LENGTH:   cfg_ff.max_payload_length <= csr_data;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

endmodule

// File: src/crcfc_in_reg.sv
// ----------------------------------------------------------------------------
// crcfc_in_reg
// Input register: holds one received item until the parser takes it.
// ----------------------------------------------------------------------------
module crcfc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crcfc_pkg::req_type req_data,
   input  logic               take,
   output logic               hold_valid,
   output crcfc_pkg::req_type hold_data
);
   import crcfc_pkg::*;

   logic    valid_ff;
   req_type data_ff;

   assign req_ready  = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

// File: src/crcfc_parser.sv
// ----------------------------------------------------------------------------
// crcfc_parser
// Frame parser: layout checks, CRC accumulation and result forming.
// ----------------------------------------------------------------------------
module crcfc_parser (
   input  logic               clock,
   input  logic               reset,
   input  crcfc_pkg::cfg_type cfg,
   input  logic               hold_valid,
   input  crcfc_pkg::req_type hold_data,
   input  logic               slot_free,
   output logic               take,
   output logic               res_valid,
   output crcfc_pkg::rsp_type res_data
);
   import crcfc_pkg::*;

   typedef enum logic [2:0] {
      PH_START, PH_LEN, PH_PAYLOAD, PH_CRC, PH_STOP, PH_DONE, PH_DISCARD
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] idx_ff, idx_in;
   logic [9:0] len_lo_ff, len_lo_in;
   logic       len_hi_ff, len_hi_in;      // any declared length bit above bit 9
   logic [9:0] count_ff, count_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcrc_ff, rcrc_in;
   logic [3:0] total_ff, total_in;
   status_type err_ff, err_in;

   logic [7:0] b;
   logic       emit;
   logic [9:0] limit;
   logic       len_known;
   status_type st;

   assign b     = hold_data.rx_byte;
   assign take  = hold_valid && slot_free;
   assign limit = (cfg.max_payload_length < FRAME_LEN_LIMIT) ?
                  cfg.max_payload_length : FRAME_LEN_LIMIT;

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      len_lo_in = len_lo_ff;
      len_hi_in = len_hi_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      rcrc_in   = rcrc_ff;
      err_in    = err_ff;
      emit      = 1'b0;
      total_in  = (total_ff < 4'd11) ? total_ff + 4'd1 : total_ff;

      unique case (phase_ff)
         PH_START: begin
            if (b == cfg.start_marker) begin
               phase_in = PH_LEN;
               idx_in   = 2'd0;
            end else begin
               err_in   = ST_BAD_START;
               phase_in = PH_DISCARD;
            end
         end
         PH_LEN: begin
            case (idx_ff)
               2'd0:    len_lo_in[7:0] = len_lo_ff[7:0] | b;
               2'd1: begin
                  len_lo_in[9:8] = len_lo_ff[9:8] | b[1:0];
                  len_hi_in      = len_hi_ff | (|b[7:2]);
               end
               default: len_hi_in = len_hi_ff | (|b);
            endcase
            if (idx_ff == 2'd3) begin
               idx_in   = 2'd0;
               count_in = 10'd0;
               if (len_hi_in || (len_lo_in > limit)) begin
                  err_in   = ST_TOO_LONG;
                  phase_in = PH_DISCARD;
               end else if (len_lo_in == 10'd0) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            crc_in   = crc32_byte(crc_ff, b);
            emit     = 1'b1;
            count_in = count_ff + 10'd1;
            if (count_in >= len_lo_ff) begin
               phase_in = PH_CRC;
               idx_in   = 2'd0;
            end
         end
         PH_CRC: begin
            case (idx_ff)
               2'd0:    rcrc_in[7:0]   = rcrc_ff[7:0]   | b;
               2'd1:    rcrc_in[15:8]  = rcrc_ff[15:8]  | b;
               2'd2:    rcrc_in[23:16] = rcrc_ff[23:16] | b;
               default: rcrc_in[31:24] = rcrc_ff[31:24] | b;
            endcase
            if (idx_ff == 2'd3) begin
               idx_in   = 2'd0;
               phase_in = PH_STOP;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         PH_STOP: begin
            if (err_ff == ST_OK) begin
               if (b != cfg.stop_marker) begin
                  err_in = ST_BAD_STOP;
               end else if (~crc_ff != rcrc_ff) begin
                  err_in = ST_CRC;
               end
            end
            phase_in = PH_DONE;
         end
         default: ;  // done or discarding: hold
      endcase

      len_known = (phase_in == PH_PAYLOAD) || (phase_in == PH_CRC) ||
                  (phase_in == PH_STOP) || (phase_in == PH_DONE) ||
                  ((phase_in == PH_DISCARD) && (err_in == ST_TOO_LONG));

      if (total_in <= 4'd10) begin
         st = ST_SHORT;
      end else if (err_in != ST_OK) begin
         st = err_in;
      end else if (phase_in != PH_DONE) begin
         st = ST_EARLY;
      end else begin
         st = ST_OK;
      end

      res_data = '0;
      if (hold_data.reception_end) begin
         res_data.item_kind      = KIND_STATUS;
         res_data.frame_status   = st;
         res_data.payload_length = !len_known ? 10'd0 : (len_hi_in ? LEN_CAP : len_lo_in);
      end else begin
         res_data.item_kind    = KIND_PAYLOAD;
         res_data.payload_byte = b;
      end
      res_valid = take && (hold_data.reception_end || emit);
   end

   always_ff @(posedge clock) begin
      if (reset || (take && hold_data.reception_end)) begin
         phase_ff  <= PH_START;
         idx_ff    <= 2'd0;
         len_lo_ff <= 10'd0;
         len_hi_ff <= 1'b0;
         count_ff  <= 10'd0;
         crc_ff    <= CRC_INIT;
         rcrc_ff   <= 32'd0;
         total_ff  <= 4'd0;
         err_ff    <= ST_OK;
      end else if (take) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         len_lo_ff <= len_lo_in;
         len_hi_ff <= len_hi_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         rcrc_ff   <= rcrc_in;
         total_ff  <= total_in;
         err_ff    <= err_in;
      end
   end

endmodule

// File: src/crcfc_rsp_reg.sv
// ----------------------------------------------------------------------------
// crcfc_rsp_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module crcfc_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  crcfc_pkg::rsp_type load_data,
   output logic               slot_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output crcfc_pkg::rsp_type rsp_data
);
   import crcfc_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (slot_free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// File: src/crcfc_checker.sv
// ----------------------------------------------------------------------------
// crcfc_checker
// Port-level checks of the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module crcfc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input crcfc_pkg::rsp_type rsp_data
);
   import crcfc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.item_kind == KIND_PAYLOAD) |->
      (rsp_data.frame_status == ST_OK) && (rsp_data.payload_length == 10'd0))
      else $error("payload item carries status fields");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.item_kind == KIND_STATUS) |->
      (rsp_data.payload_byte == 8'd0) && (rsp_data.frame_status <= ST_TOO_LONG) &&
      (rsp_data.payload_length <= LEN_CAP))
      else $error("malformed status item");

endmodule

bind crc32_frame_checker crcfc_checker u_crcfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
